FILE: rtl/pidaw_pkg.sv
// Shared types and constants for the PID controller with dynamic anti-windup.
// Used by the channel interfaces, the controller, the datapath and the multiplier.
package pidaw_pkg;

  // value format default (signed fixed point)
  localparam int VALUE_WIDTH_DEF = 32;

  // gain and period formats
  localparam int GAIN_W       = 24;
  localparam int PERIOD_W     = 24;
  localparam int GAIN_SHIFT   = 16;
  localparam int PERIOD_SHIFT = 24;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_ISOLATE = 3'd6;

  // item command codes
  localparam logic CMD_RUN   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // datapath step codes
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_KE    = 3'd1,  // issue ki*e, form error difference
    OP_P     = 3'd2,  // issue kp*e, store ki*e
    OP_INC   = 3'd3,  // issue (ki*e)*ts, store P
    OP_D     = 3'd4,  // issue kd*de, store increment, integral bounds
    OP_INTEG = 3'd5,  // store D, update integral
    OP_SUM   = 3'd6,  // P + I + D
    OP_FIN   = 3'd7   // clamp and load result register
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear;     // captured word is a clear command
    logic out_busy;  // result register full and not taken this cycle
  } dp_status_t;

endpackage

FILE: rtl/pidaw_if.sv
// Valid/ready channel interfaces for the PID controller: input word and result word.
// Depends on pidaw_pkg for the default value width.
interface pidaw_item_if import pidaw_pkg::*; #(
  parameter int VW = VALUE_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic signed [VW-1:0] setpoint;
  logic signed [VW-1:0] measured;

  modport source (output valid, command, setpoint, measured, input ready);
  modport sink   (input valid, command, setpoint, measured, output ready);
endinterface

interface pidaw_result_if import pidaw_pkg::*; #(
  parameter int VW = VALUE_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] drive;
  logic                 drive_limited;

  modport source (output valid, drive, drive_limited, input ready);
  modport sink   (input valid, drive, drive_limited, output ready);
endinterface

FILE: rtl/pid_controller_dynamic_antiwindup_top.sv
// Top level of the parallel PID controller with dynamic anti-windup.
// Depends on pidaw_pkg, pidaw_if, pidaw_mul, pidaw_dp and pidaw_ctrl.
//
//   channel  role    handshake      word
//   item     sink    valid/ready    command, setpoint, measured
//   result   source  valid/ready    drive, drive_limited
//   cfg      sink    cfg_wr_en      cfg_index, cfg_data (no read-back)
//
// A run word steps through the states KE, P, INC, D, INTEG, SUM and FIN: four
// products go through the one shared multiplier, one per cycle, overlapped
// with the term updates. A clear word goes from KE straight to FIN.
// Reset (rst, synchronous) zeroes the configuration registers, result valid, integral and previous error.
// A stalled result holds in its register; the next word is still accepted and
// its step waits in the finish state until the register is free.
module pid_controller_dynamic_antiwindup_top import pidaw_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int CFG_W       = (VALUE_WIDTH > GAIN_W) ? VALUE_WIDTH : GAIN_W
) (
  input  logic                  clk,
  input  logic                  rst,
  pidaw_item_if.sink            item,
  pidaw_result_if.source        result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  pidaw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  pidaw_dp #(.VW(VALUE_WIDTH), .CW(CFG_W)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .item_command   (item.command),
    .item_setpoint  (item.setpoint),
    .item_measured  (item.measured),
    .result_ready   (result.ready),
    .result_valid   (result.valid),
    .result_drive   (result.drive),
    .result_limited (result.drive_limited),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

endmodule

FILE: rtl/pidaw_mul.sv
// Shared sign-magnitude multiplier: registered product, then shift, sign and saturate.
// Depends on pidaw_pkg for the gain and period formats.
module pidaw_mul import pidaw_pkg::*; #(
  parameter int VW = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] a,
  input  logic signed [GAIN_W:0] b,
  input  logic                 period,
  output logic signed [VW-1:0] res
);

  localparam int PW = VW + PERIOD_W;
  localparam logic [PW-1:0] POS_LIM = {{(PW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic [PW-1:0] NEG_LIM = {{(PW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  logic [VW-1:0]       mag_a;
  logic [GAIN_W:0]     neg_b;
  logic [PERIOD_W-1:0] mag_b;
  logic [PW-1:0]       prod;
  logic                neg;
  logic                shift_period;
  logic [PW-1:0]       shifted;
  logic [VW-1:0]       low_bits;

  // magnitudes of the operands
  always_comb begin
    neg_b = ~b + 1'b1;
    mag_a = a[VW-1] ? (~a + 1'b1) : a;
    mag_b = b[GAIN_W] ? neg_b[PERIOD_W-1:0] : b[PERIOD_W-1:0];
  end

  // product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod         <= PW'(mag_a) * PW'(mag_b);
      neg          <= a[VW-1] ^ b[GAIN_W];
      shift_period <= period;
    end
  end

  // truncate toward zero, apply sign, saturate
  always_comb begin
    shifted  = shift_period ? (prod >> PERIOD_SHIFT) : (prod >> GAIN_SHIFT);
    low_bits = shifted[VW-1:0];
    if (!neg) begin
      res = (shifted > POS_LIM) ? VMAX : $signed(low_bits);
    end else begin
      res = (shifted > NEG_LIM) ? VMIN : $signed(~low_bits + 1'b1);
    end
  end

endmodule

FILE: rtl/pidaw_dp.sv
// Datapath of the PID controller: configuration, history, term registers, result register.
// Depends on pidaw_pkg and instantiates pidaw_mul.
module pidaw_dp import pidaw_pkg::*; #(
  parameter int VW = VALUE_WIDTH_DEF,
  parameter int CW = (VW > GAIN_W) ? VW : GAIN_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic                 item_command,
  input  logic signed [VW-1:0] item_setpoint,
  input  logic signed [VW-1:0] item_measured,
  input  logic                 result_ready,
  output logic                 result_valid,
  output logic signed [VW-1:0] result_drive,
  output logic                 result_limited,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_data
);

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ZERO = '0;

  // saturate a one-bit-wider difference or sum
  function automatic logic signed [VW-1:0] sat1(input logic signed [VW:0] v);
    logic signed [VW-1:0] r;
    if (v[VW] != v[VW-1]) begin
      r = v[VW] ? VMIN : VMAX;
    end else begin
      r = v[VW-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic signed [GAIN_W-1:0]   prop_gain;
  logic signed [GAIN_W-1:0]   integ_gain;
  logic signed [GAIN_W-1:0]   deriv_gain;
  logic        [PERIOD_W-1:0] sample_period;
  logic signed [VW-1:0]       drive_upper;
  logic signed [VW-1:0]       drive_lower;
  logic                       integ_isolate;

  // history and working registers
  logic                 cmd_word;
  logic signed [VW-1:0] err;
  logic signed [VW-1:0] diff;
  logic signed [VW-1:0] last_error;
  logic signed [VW-1:0] integral_acc;
  logic signed [VW-1:0] ke;
  logic signed [VW-1:0] p_term;
  logic signed [VW-1:0] inc;
  logic signed [VW-1:0] d_term;
  logic signed [VW-1:0] imax;
  logic signed [VW-1:0] imin;
  logic signed [VW+1:0] sum;

  // multiplier hookup
  logic                  mul_en;
  logic signed [VW-1:0]  mul_a;
  logic signed [GAIN_W:0] mul_b;
  logic                  mul_period;
  logic signed [VW-1:0]  mul_res;

  logic signed [VW-1:0] imax_raw;
  logic signed [VW-1:0] imin_raw;
  logic signed [VW-1:0] acc_sum;
  logic signed [VW+1:0] upper_ext;
  logic signed [VW+1:0] lower_ext;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= '0;
      integ_gain    <= '0;
      deriv_gain    <= '0;
      sample_period <= '0;
      drive_upper   <= '0;
      drive_lower   <= '0;
      integ_isolate <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     prop_gain     <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:    integ_gain    <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:    deriv_gain    <= cfg_data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_data[PERIOD_W-1:0];
        REG_DRIVE_UPPER:   drive_upper   <= cfg_data[VW-1:0];
        REG_DRIVE_LOWER:   drive_lower   <= cfg_data[VW-1:0];
        REG_INTEG_ISOLATE: integ_isolate <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en     = 1'b0;
    mul_a      = err;
    mul_b      = {prop_gain[GAIN_W-1], prop_gain};
    mul_period = 1'b0;
    unique case (cmd.op)
      OP_KE: begin
        mul_en = 1'b1;
        mul_b  = {integ_gain[GAIN_W-1], integ_gain};
      end
      OP_P: begin
        mul_en = 1'b1;
      end
      OP_INC: begin
        mul_en     = 1'b1;
        mul_a      = ke;
        mul_b      = {1'b0, sample_period};
        mul_period = 1'b1;
      end
      OP_D: begin
        mul_en = 1'b1;
        mul_a  = diff;
        mul_b  = {deriv_gain[GAIN_W-1], deriv_gain};
      end
      OP_NONE, OP_INTEG, OP_SUM, OP_FIN: ;
    endcase
  end

  pidaw_mul #(.VW(VW)) u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .period (mul_period),
    .res    (mul_res)
  );

  // bounds, integral step, limits widened for the sum compare
  always_comb begin
    imax_raw  = sat1((VW+1)'(drive_upper) - (VW+1)'(p_term));
    imin_raw  = sat1((VW+1)'(drive_lower) - (VW+1)'(p_term));
    acc_sum   = sat1((VW+1)'(integral_acc) + (VW+1)'(inc));
    upper_ext = (VW+2)'(drive_upper);
    lower_ext = (VW+2)'(drive_lower);
  end

  // history: cleared by reset or a clear word
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      last_error   <= '0;
    end else if (cmd.load && item_command == CMD_CLEAR) begin
      integral_acc <= '0;
      last_error   <= '0;
    end else if (cmd.op == OP_KE) begin
      last_error <= err;
    end else if (cmd.op == OP_INTEG) begin
      if (integ_isolate) begin
        integral_acc <= '0;
      end else if (acc_sum > imax) begin
        integral_acc <= imax;
      end else if (acc_sum < imin) begin
        integral_acc <= imin;
      end else begin
        integral_acc <= acc_sum;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_word <= item_command;
      err      <= sat1((VW+1)'(item_setpoint) - (VW+1)'(item_measured));
    end
    unique case (cmd.op)
      OP_KE:  diff   <= sat1((VW+1)'(err) - (VW+1)'(last_error));
      OP_P:   ke     <= mul_res;
      OP_INC: p_term <= mul_res;
      OP_D: begin
        inc  <= mul_res;
        imax <= (imax_raw < ZERO) ? ZERO : imax_raw;
        imin <= (imin_raw > ZERO) ? ZERO : imin_raw;
      end
      OP_INTEG: d_term <= mul_res;
      OP_SUM:   sum <= (VW+2)'(p_term) + (VW+2)'(integral_acc) + (VW+2)'(d_term);
      OP_NONE, OP_FIN: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == OP_FIN) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FIN) begin
      if (cmd_word == CMD_CLEAR) begin
        result_drive   <= '0;
        result_limited <= 1'b0;
      end else if (sum > upper_ext) begin
        result_drive   <= drive_upper;
        result_limited <= 1'b1;
      end else if (sum < lower_ext) begin
        result_drive   <= drive_lower;
        result_limited <= 1'b1;
      end else begin
        result_drive   <= sum[VW-1:0];
        result_limited <= 1'b0;
      end
    end
  end

  assign status.clear    = (cmd_word == CMD_CLEAR);
  assign status.out_busy = result_valid && !result_ready;

`ifndef SYNTH
  // integral lands inside its dynamic bounds
  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_INTEG && !integ_isolate) |=> (integral_acc <= imax && integral_acc >= imin))
    else $error("integral outside dynamic bounds");

  // isolate forces the integral to zero
  a_integ_isolate: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_INTEG && integ_isolate) |=> (integral_acc == ZERO))
    else $error("integral not zero while isolated");

  // clear word wipes the history
  a_clear_history: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && item_command == CMD_CLEAR) |=> (integral_acc == ZERO && last_error == ZERO))
    else $error("history not cleared");

  // result register never overwritten while a word waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FIN) |-> !status.out_busy)
    else $error("result overwritten before taken");
`endif

endmodule

FILE: rtl/pidaw_ctrl.sv
// Step sequencer of the PID controller: orders multiplier use and term updates.
// Depends on pidaw_pkg for the command and status structs.
module pidaw_ctrl import pidaw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_KE    = 8'b0000_0010,
    S_P     = 8'b0000_0100,
    S_INC   = 8'b0000_1000,
    S_D     = 8'b0001_0000,
    S_INTEG = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // no word is taken while reset is held
  assign item_ready = (state == S_IDLE) && !rst;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        cmd.load = item_valid && item_ready;
        if (item_valid && item_ready) begin
          state_next = S_KE;
        end
      end
      S_KE: begin
        if (status.clear) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_KE;
          state_next = S_P;
        end
      end
      S_P: begin
        cmd.op     = OP_P;
        state_next = S_INC;
      end
      S_INC: begin
        cmd.op     = OP_INC;
        state_next = S_D;
      end
      S_D: begin
        cmd.op     = OP_D;
        state_next = S_INTEG;
      end
      S_INTEG: begin
        cmd.op     = OP_INTEG;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = OP_SUM;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.op     = OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  // a word is only taken in idle, and work starts right after
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_KE))
    else $error("accepted word did not start a step");

  // a finished step returns to idle once the result register is free
  a_fin_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !status.out_busy) |=> (state == S_IDLE))
    else $error("stuck in finish");

  // datapath steps never issue while a word may be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> (cmd.op == OP_NONE))
    else $error("datapath step issued in idle");
`endif

endmodule

FILE: dv/pid_controller_dynamic_antiwindup_top_tb.sv
// Testbench for pid_controller_dynamic_antiwindup_top: drives control and clear words, predicts
// each drive word from its own fixed-point controller model and checks it field by field.
// Depends on pidaw_pkg, pidaw_if and the controller RTL.
module pid_controller_dynamic_antiwindup_top_tb import pidaw_pkg::*; ();

  localparam int     CYCLE_LIMIT = 600000;
  localparam longint VAL_MAX     = 64'sd2147483647;
  localparam longint VAL_MIN     = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [31:0] Q16_ONE = 32'sd65536;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               limited;
  } drive_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  pidaw_item_if   item_ch();
  pidaw_result_if result_ch();

  pid_controller_dynamic_antiwindup_top u_top (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // controller model state and registers
  longint kp_q, ki_q, kd_q, period_q, upper_q, lower_q;
  logic   isolate_q;
  longint integ_q, prev_err_q;

  drive_word_t drive_q[$];
  drive_word_t want;
  int          mismatch_count;
  int          cycle_count;
  bit          src_idle;
  bit          snk_idle;
  int          hold_cycles;

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint clip32(longint v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return v;
  endfunction

  // magnitude product, truncated toward zero, then signed and saturated
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic   neg;
    longint ma, mb, r;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    r   = (ma * mb) >>> sh;
    return clip32(neg ? -r : r);
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      REG_PROP_GAIN:     kp_q = longint'($signed(data[23:0]));
      REG_INTEG_GAIN:    ki_q = longint'($signed(data[23:0]));
      REG_DERIV_GAIN:    kd_q = longint'($signed(data[23:0]));
      REG_SAMPLE_PERIOD: period_q = longint'({1'b0, data[23:0]});
      REG_DRIVE_UPPER:   upper_q = longint'($signed(data));
      REG_DRIVE_LOWER:   lower_q = longint'($signed(data));
      REG_INTEG_ISOLATE: isolate_q = data[0];
      default: ;
    endcase
  endfunction

  // one controller step: P + clamped I + D, then output clamp
  function automatic drive_word_t predict_drive(logic cmd, logic signed [31:0] sp,
                                                logic signed [31:0] ms);
    drive_word_t w;
    longint err, p, d, imax, imin, ke, inc, sum;
    w.drive   = '0;
    w.limited = 1'b0;
    if (cmd == CMD_CLEAR) begin
      integ_q    = 0;
      prev_err_q = 0;
    end else begin
      err = clip32(longint'(sp) - longint'(ms));
      p   = scaled_product(err, kp_q, GAIN_SHIFT);
      d   = scaled_product(clip32(err - prev_err_q), kd_q, GAIN_SHIFT);
      prev_err_q = err;
      imax = clip32(upper_q - p);
      if (imax < 0) imax = 0;
      imin = clip32(lower_q - p);
      if (imin > 0) imin = 0;
      if (isolate_q) begin
        integ_q = 0;
      end else begin
        ke  = scaled_product(err, ki_q, GAIN_SHIFT);
        inc = scaled_product(ke, period_q, PERIOD_SHIFT);
        integ_q = clip32(integ_q + inc);
        if (integ_q > imax) integ_q = imax;
        else if (integ_q < imin) integ_q = imin;
      end
      sum = p + integ_q + d;
      if (sum > upper_q) begin
        sum = upper_q;
        w.limited = 1'b1;
      end else if (sum < lower_q) begin
        sum = lower_q;
        w.limited = 1'b1;
      end
      w.drive = sum[31:0];
    end
    return w;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (drive_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: drive %0d limited %0b",
                   result_ch.drive, result_ch.drive_limited);
      end else begin
        want = drive_q.pop_front();
        if (result_ch.drive !== want.drive || result_ch.drive_limited !== want.limited) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: drive exp %0d got %0d, limited exp %0b got %0b",
                     want.drive, result_ch.drive, want.limited, result_ch.drive_limited);
        end
      end
    end
  end

  // result receiver: random stall per word, plus an optional long hold-off
  initial begin : result_sink
    int stall;
    result_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        result_ch.ready = 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      stall = snk_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  // send one word; entered and left just after a falling edge
  task automatic send_word(input logic cmd, input logic signed [31:0] sp,
                           input logic signed [31:0] ms);
    int gap;
    gap = src_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid    = 1'b1;
    item_ch.command  = cmd;
    item_ch.setpoint = sp;
    item_ch.measured = ms;
    do @(posedge clk); while (!item_ch.ready);
    drive_q.push_back(predict_drive(cmd, sp, ms));
    @(negedge clk);
  endtask

  task automatic run_word(input logic signed [31:0] sp, input logic signed [31:0] ms);
    send_word(CMD_RUN, sp, ms);
  endtask

  // stop sending and wait until every expected word has come back
  task automatic settle();
    item_ch.valid = 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    model_write(idx, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic write_all(input logic [31:0] kp, input logic [31:0] ki,
                           input logic [31:0] kd, input logic [31:0] ts,
                           input logic [31:0] hi, input logic [31:0] lo, input logic iso);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_SAMPLE_PERIOD, ts);
    write_reg(REG_DRIVE_UPPER, hi);
    write_reg(REG_DRIVE_LOWER, lo);
    write_reg(REG_INTEG_ISOLATE, {31'd0, iso});
  endtask

  function automatic logic signed [31:0] signed_span(int unsigned mag);
    logic signed [31:0] v;
    v = mag;
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return {8'd0, 24'($urandom)};
      2: return ($urandom_range(0, 1) == 1) ? 32'h00800000 : 32'h007fffff;
      default: return {8'd0, 24'(signed_span($urandom_range(0, 4 * 65536)))};
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'h00ffffff;
      2: return {8'd0, 24'($urandom)};
      default: return $urandom_range(1, 400000);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_target();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return signed_span($urandom_range(0, 200 * 65536));
  endfunction

  // random register setting, limits ordered, crossed, extreme or wild
  task automatic random_setting();
    logic signed [31:0] a, b;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        a = signed_span($urandom_range(0, 1000 * 65536));
        b = signed_span($urandom_range(0, 1000 * 65536));
        if (a < b) begin
          a = a ^ b; b = a ^ b; a = a ^ b;
        end
      end
      3: begin
        a = 32'sh7fffffff;
        b = 32'sh80000000;
      end
      4: begin
        a = -signed_span($urandom_range(0, 50 * 65536));
        b = a + $urandom_range(1, 20 * 65536);
      end
      default: begin
        a = $urandom;
        b = $urandom;
      end
    endcase
    write_all(pick_gain(), pick_gain(), pick_gain(), pick_period(), a, b,
              $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  // all registers at reset value: every run word gives zero
  task automatic test_reset_values();
    run_word(32'sd5 * Q16_ONE, 32'sd0);
    send_word(CMD_CLEAR, 32'sd7, -32'sd7);
    settle();
  endtask

  // plain terms, saturating error, clear of history
  task automatic test_basic_terms();
    write_all(Q16_ONE, 2 * Q16_ONE, Q16_ONE / 2, 32'h00400000,
              50 * Q16_ONE, -50 * Q16_ONE, 1'b0);
    run_word(10 * Q16_ONE, 0);
    run_word(10 * Q16_ONE, 2 * Q16_ONE);
    run_word(10 * Q16_ONE, 8 * Q16_ONE);
    run_word(0, 0);
    send_word(CMD_CLEAR, 32'sh7fffffff, 32'sh80000000);
    run_word(3 * Q16_ONE, Q16_ONE);
    run_word(32'sh7fffffff, 32'sh80000000);
    run_word(32'sh80000000, 32'sh7fffffff);
    run_word(-32'sd1, 32'sd0);
    settle();
  endtask

  // integral pushed against the dynamic bounds in both directions
  task automatic test_windup();
    write_all(Q16_ONE / 2, 8 * Q16_ONE, 32'd0, 32'h00ffffff,
              20 * Q16_ONE, -20 * Q16_ONE, 1'b0);
    repeat (4) run_word(30 * Q16_ONE, 0);
    repeat (2) run_word(-30 * Q16_ONE, 0);
    settle();
  endtask

  // isolate forces the integral to zero
  task automatic test_isolate();
    write_reg(REG_INTEG_ISOLATE, 32'd1);
    run_word(15 * Q16_ONE, 0);
    run_word(-5 * Q16_ONE, 0);
    settle();
  endtask

  // crossed limits, extreme gains and period, write to an unknown index
  task automatic test_crossed_extremes();
    write_all(32'h007fffff, 32'h00800000, 32'h00800000, 32'h00ffffff,
              -10 * Q16_ONE, 10 * Q16_ONE, 1'b0);
    write_reg(REG_UNUSED, 32'hffffffff);
    run_word(32'sh7fffffff, 32'sh80000000);
    run_word(0, 5 * Q16_ONE);
    run_word(32'sh80000000, 32'sh7fffffff);
    settle();
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    src_idle    = 1'b0;
    snk_idle    = 1'b0;
    hold_cycles = 150;
    repeat (12) run_word(signed_span($urandom_range(0, 40 * 65536)),
                         signed_span($urandom_range(0, 40 * 65536)));
    settle();
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  // random phases: mostly tracking a target, some noise, extremes and clears
  task automatic test_random(input int total);
    int sent, phase_len, k;
    int unsigned pick;
    logic signed [31:0] target, sp, ms;
    sent = 0;
    while (sent < total) begin
      settle();
      random_setting();
      src_idle  = $urandom_range(0, 3) != 0;
      snk_idle  = $urandom_range(0, 3) != 0;
      target    = pick_target();
      phase_len = $urandom_range(40, 120);
      for (k = 0; k < phase_len; k++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) target = pick_target();
        if (pick < 4) begin
          send_word(CMD_CLEAR, $urandom, $urandom);
        end else begin
          if (pick < 70) begin
            sp = target;
            ms = target - signed_span($urandom_range(0, 1 << 18));
          end else if (pick < 90) begin
            sp = $urandom;
            ms = $urandom;
          end else begin
            sp = pick_extreme();
            ms = pick_extreme();
          end
          run_word(sp, ms);
        end
      end
      sent += phase_len;
    end
    settle();
  endtask

  initial begin
    item_ch.valid    = 1'b0;
    item_ch.command  = CMD_RUN;
    item_ch.setpoint = '0;
    item_ch.measured = '0;
    cfg_wr_en        = 1'b0;
    cfg_index        = REG_PROP_GAIN;
    cfg_data         = '0;
    mismatch_count   = 0;
    cycle_count      = 0;
    hold_cycles      = 0;
    src_idle         = 1'b1;
    snk_idle         = 1'b1;
    kp_q = 0; ki_q = 0; kd_q = 0; period_q = 0; upper_q = 0; lower_q = 0;
    isolate_q = 1'b0; integ_q = 0; prev_err_q = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_basic_terms();
    test_windup();
    test_isolate();
    test_crossed_extremes();
    test_backpressure();
    test_random(1600);

    if (mismatch_count == 0 && drive_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
